/* sv/cdd_pkg.sv */
// Package for the calendar day difference block: control word types,
// the microprogram ROM and the Gregorian calendar lookups.
// Depends on nothing; used by calendar_day_difference.
`timescale 1ns / 1ps

package cdd_pkg;

  localparam int unsigned PC_W = 3;

  typedef logic [PC_W-1:0] pc_t;

  // Microprogram addresses.
  localparam pc_t PC_CLASSIFY = 3'd0;
  localparam pc_t PC_SUB_SM   = 3'd1;
  localparam pc_t PC_SET_Y    = 3'd2;
  localparam pc_t PC_ADD_Y    = 3'd3;
  localparam pc_t PC_SET_M    = 3'd4;
  localparam pc_t PC_ADD_EM   = 3'd5;
  localparam pc_t PC_ADD_ED   = 3'd6;
  localparam pc_t PC_SAME_Y   = 3'd7;

  // One past the last real month; the start-month loop never goes beyond it.
  localparam logic [7:0] MONTH_END = 8'd13;

  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_INIT,
    ACC_SUB_ML,
    ACC_ADD_YL,
    ACC_ADD_ML,
    ACC_ADD_ED
  } acc_sel_t;

  typedef enum logic [2:0] {
    CNT_HOLD,
    CNT_INIT,
    CNT_SY1,
    CNT_ONE,
    CNT_INC
  } cnt_sel_t;

  typedef enum logic [1:0] {
    COND_NONE,
    COND_SM,
    COND_EY,
    COND_EM
  } cond_sel_t;

  typedef enum logic {
    YR_SY,
    YR_EY
  } yr_sel_t;

  typedef struct packed {
    acc_sel_t  acc_sel;
    cnt_sel_t  cnt_sel;
    cond_sel_t cond;
    yr_sel_t   yr_sel;
    logic      dispatch;
    logic      fin;
    pc_t       nxt;
  } ctl_word_t;

  // A conditional word repeats while its condition holds and moves to nxt
  // (or finishes) once it fails; the acc and counter ops run only on repeats.
  function automatic ctl_word_t cdd_rom(input pc_t pc);
    ctl_word_t w;
    w = '{ACC_HOLD, CNT_HOLD, COND_NONE, YR_SY, 1'b0, 1'b0, PC_CLASSIFY};
    unique case (pc)
      PC_CLASSIFY: w = '{ACC_INIT,   CNT_INIT, COND_NONE, YR_SY, 1'b1, 1'b0, PC_SUB_SM};
      PC_SUB_SM:   w = '{ACC_SUB_ML, CNT_INC,  COND_SM,   YR_SY, 1'b0, 1'b0, PC_SET_Y};
      PC_SET_Y:    w = '{ACC_HOLD,   CNT_SY1,  COND_NONE, YR_SY, 1'b0, 1'b0, PC_ADD_Y};
      PC_ADD_Y:    w = '{ACC_ADD_YL, CNT_INC,  COND_EY,   YR_SY, 1'b0, 1'b0, PC_SET_M};
      PC_SET_M:    w = '{ACC_HOLD,   CNT_ONE,  COND_NONE, YR_SY, 1'b0, 1'b0, PC_ADD_EM};
      PC_ADD_EM:   w = '{ACC_ADD_ML, CNT_INC,  COND_EM,   YR_EY, 1'b0, 1'b0, PC_ADD_ED};
      PC_ADD_ED:   w = '{ACC_ADD_ED, CNT_HOLD, COND_NONE, YR_SY, 1'b0, 1'b1, PC_CLASSIFY};
      PC_SAME_Y:   w = '{ACC_ADD_ML, CNT_INC,  COND_EM,   YR_SY, 1'b0, 1'b1, PC_CLASSIFY};
      default:     w = '{ACC_HOLD,   CNT_HOLD, COND_NONE, YR_SY, 1'b0, 1'b1, PC_CLASSIFY};
    endcase
    return w;
  endfunction

  // Years are offsets from 2000, which is itself a leap year, so within an
  // eight-bit offset only 2100 and 2200 break the every-fourth-year rule.
  function automatic logic is_leap(input logic [7:0] y);
    return (y[1:0] == 2'b00) && (y != 8'd100) && (y != 8'd200);
  endfunction

  function automatic logic [4:0] month_len(input logic leap, input logic [7:0] m);
    logic [4:0] len;
    case (m)
      8'd1, 8'd3, 8'd5, 8'd7, 8'd8, 8'd10, 8'd12: len = 5'd31;
      8'd4, 8'd6, 8'd9, 8'd11:                     len = 5'd30;
      8'd2:                                        len = leap ? 5'd29 : 5'd28;
      default:                                     len = 5'd0;
    endcase
    return len;
  endfunction

  function automatic logic [8:0] year_len(input logic [7:0] y);
    return is_leap(y) ? 9'd366 : 9'd365;
  endfunction

endpackage

/* sv/calendar_day_difference.sv */
// Top level of the calendar day difference block: handshake, input capture,
// a microcoded sequencer over an accumulator and a counter, output register.
// Depends on cdd_pkg for the control word ROM and calendar lookups.
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Payload
// in_       input      in_valid / in_stall    end/start year, month, day (8 bits each)
// out_      output     out_valid / out_stall  day_count (16 bits)
// cfg_      input      cfg_we                 cfg_wdata (reversed order value)
//
// One item at a time; a rejected, reversed or same-month item ends at classification,
// and the longest items are set by the year loop of the sequencer, one year per cycle unless stalled,
// plus up to 12 start months and 11 end months at one month per cycle.
// rst_n is synchronous and active low; it sets the reversed order value to 65535.
// The sequencer pauses while a finished item waits in the output register under stall.
module calendar_day_difference
  import cdd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_end_year,
  input  logic [7:0]  in_end_month,
  input  logic [7:0]  in_end_day,
  input  logic [7:0]  in_start_year,
  input  logic [7:0]  in_start_month,
  input  logic [7:0]  in_start_day,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_day_count,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t      state_r, state_nxt;
  pc_t         pc_r, pc_nxt;
  logic [15:0] acc_r, acc_nxt;
  logic [7:0]  cnt_r, cnt_nxt;
  logic [15:0] cap_r;
  logic [7:0]  ey_r, em_r, ed_r, sy_r, sm_r, sd_r;
  logic        out_valid_r, out_valid_nxt;
  logic [15:0] out_day_count_r;

  ctl_word_t   cw;
  logic        step_en, cond_ok, exec, finish;
  logic        bad_item, reversed, same_year, same_month;
  logic [15:0] init_val;
  logic [4:0]  ml_val;
  logic [8:0]  yl_val;
  logic        in_accept;

  assign in_stall      = (state_r != ST_IDLE);
  assign in_accept     = in_valid && !in_stall;
  assign out_valid     = out_valid_r;
  assign out_day_count = out_day_count_r;

  // Classification of the captured item, used by the first microword.
  always_comb begin
    bad_item   = (em_r < 8'd1) || (em_r > 8'd12) || (ed_r < 8'd1) || (ed_r > 8'd31)
                 || (sy_r == 8'd0);
    same_year  = (ey_r == sy_r);
    same_month = same_year && (em_r == sm_r);
    reversed   = (ey_r < sy_r) || (same_year && (em_r < sm_r))
                 || (same_month && (ed_r < sd_r));
    if (bad_item) begin
      init_val = 16'd0;
    end else if (reversed) begin
      init_val = cap_r;
    end else if (same_month) begin
      init_val = {8'd0, ed_r} - {8'd0, sd_r};
    end else if (same_year) begin
      init_val = {11'd0, month_len(is_leap(sy_r), sm_r)} - {8'd0, sd_r} + {8'd0, ed_r};
    end else begin
      init_val = {7'd0, year_len(sy_r)} - {8'd0, sd_r};
    end
  end

  always_comb begin
    cw      = cdd_rom(pc_r);
    step_en = (state_r == ST_RUN) && (!out_valid_r || !out_stall);

    case (cw.cond)
      COND_SM: cond_ok = (cnt_r < sm_r) && (cnt_r < MONTH_END);
      COND_EY: cond_ok = (cnt_r < ey_r);
      COND_EM: cond_ok = (cnt_r < em_r);
      default: cond_ok = 1'b1;
    endcase
    exec = (cw.cond == COND_NONE) || cond_ok;

    ml_val = month_len(is_leap((cw.yr_sel == YR_EY) ? ey_r : sy_r), cnt_r);
    yl_val = year_len(cnt_r);

    acc_nxt = acc_r;
    cnt_nxt = cnt_r;
    pc_nxt  = pc_r;
    finish  = 1'b0;

    if (step_en) begin
      if (exec) begin
        unique case (cw.acc_sel)
          ACC_INIT:   acc_nxt = init_val;
          ACC_SUB_ML: acc_nxt = acc_r - {11'd0, ml_val};
          ACC_ADD_YL: acc_nxt = acc_r + {7'd0, yl_val};
          ACC_ADD_ML: acc_nxt = acc_r + {11'd0, ml_val};
          ACC_ADD_ED: acc_nxt = acc_r + {8'd0, ed_r};
          default:    acc_nxt = acc_r;
        endcase
        unique case (cw.cnt_sel)
          CNT_INIT: cnt_nxt = same_year ? (sm_r + 8'd1) : 8'd1;
          CNT_SY1:  cnt_nxt = sy_r + 8'd1;
          CNT_ONE:  cnt_nxt = 8'd1;
          CNT_INC:  cnt_nxt = cnt_r + 8'd1;
          default:  cnt_nxt = cnt_r;
        endcase
      end

      if ((cw.cond != COND_NONE) && cond_ok) begin
        pc_nxt = pc_r;
      end else if (cw.dispatch) begin
        if (bad_item || reversed || same_month) begin
          finish = 1'b1;
          pc_nxt = PC_CLASSIFY;
        end else if (same_year) begin
          pc_nxt = PC_SAME_Y;
        end else begin
          pc_nxt = cw.nxt;
        end
      end else begin
        finish = cw.fin;
        pc_nxt = cw.nxt;
      end
    end

    unique case (state_r)
      ST_IDLE: state_nxt = in_accept ? ST_RUN : ST_IDLE;
      ST_RUN:  state_nxt = finish ? ST_IDLE : ST_RUN;
      default: state_nxt = ST_IDLE;
    endcase

    out_valid_nxt = finish || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pc_r        <= PC_CLASSIFY;
      out_valid_r <= 1'b0;
      cap_r       <= 16'hFFFF;
    end else begin
      state_r     <= state_nxt;
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    cnt_r <= cnt_nxt;
    if (in_accept) begin
      ey_r <= in_end_year;
      em_r <= in_end_month;
      ed_r <= in_end_day;
      sy_r <= in_start_year;
      sm_r <= in_start_month;
      sd_r <= in_start_day;
    end
    if (finish) begin
      out_day_count_r <= acc_nxt;
    end
  end

  // A result appears only as the end of a sequencer run.
  a_out_from_run: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_RUN))
    else $error("result appeared without a sequencer run");

  // The captured item must not move while the sequencer works on it.
  a_item_held: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) && $past(state_r == ST_RUN) |-> $stable(ey_r) && $stable(sy_r))
    else $error("captured item changed during a run");

  // The start-month counter never goes beyond MONTH_END, one past the last month.
  a_month_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) && (pc_r == PC_SUB_SM) |-> (cnt_r <= MONTH_END))
    else $error("start-month loop ran past December");

  // Each allowed step on the first microword either leaves it or ends the run.
  a_classify_once: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) && (pc_r == PC_CLASSIFY) && step_en |=> (pc_r != PC_CLASSIFY)
    || (state_r == ST_IDLE))
    else $error("sequencer stuck on classification");

endmodule
